// ----- src/ffpa_pkg.sv -----
package ffpa_pkg;

  // Default sizing of the slot table and the time counter
  localparam int MAX_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  // Field widths fixed by the item formats
  localparam int FILL_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int BASE_W   = 12;
  localparam int ADDR_W   = 13;
  localparam int SUM_W    = 12;
  localparam int TOTAL_W  = 16;
  localparam int FIN_W    = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Register reset values
  localparam logic [COUNT_W-1:0] PART_COUNT_RST = 5'd7;
  localparam logic [FILL_W-1:0]  PART_SIZE_RST  = 8'd8;
  localparam logic [BASE_W-1:0]  OS_BASE_RST    = 12'd8;

  // Saturation limits
  localparam logic [SUM_W-1:0]   SUM_MAX   = 12'hFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PART_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OS_BASE    = 2'd2;

  // Input item kinds
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_ARRIVAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ffpa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch the item and clear the scan
    logic issue;   // read the next slot entry
    logic finish;  // load the result register
  } ffpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;       // slots left to read
    logic scan_done;  // all partitions in use read and processed
    logic out_free;   // result register can take a new result
  } ffpa_sts_t;

endpackage

// ----- src/ffpa_ram.sv -----
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/ffpa_ctrl.sv -----
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffpa_sts_t sts,
  output ffpa_cmd_t cmd
);

  ffpa_state_t state;
  ffpa_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN: begin
        cmd.issue = sts.more;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/ffpa_datapath.sv -----
module ffpa_datapath
  import ffpa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_mode,
  input  logic [FILL_W-1:0]     in_req,
  input  logic [FIN_W-1:0]      in_fin,
  input  ffpa_cmd_t             cmd,
  output ffpa_sts_t             sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int ENT_W = FILL_W + TIME_BITS;

  logic [COUNT_W-1:0]   part_count;
  logic [FILL_W-1:0]    part_size;
  logic [BASE_W-1:0]    os_base;
  logic [CNT_W-1:0]     count_use;

  logic                 mode_q;
  logic [FILL_W-1:0]    req_q;
  logic [TIME_BITS-1:0] fin_q;
  logic [TIME_BITS-1:0] time_q;
  logic [TOTAL_W-1:0]   arrivals_q;
  logic [TOTAL_W-1:0]   failures_q;
  logic [TOTAL_W-1:0]   failures_next;

  logic [CNT_W-1:0]     rd_idx;
  logic                 proc_vld;
  logic [IDX_W-1:0]     proc_idx;
  logic [ADDR_W-1:0]    addr_acc;
  logic                 placed_q;
  logic [IDX_W-1:0]     slot_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [SUM_W-1:0]     waste_acc;
  logic [SUM_W-1:0]     used_acc;
  logic [CNT_W-1:0]     freed_q;
  logic [MAX_SLOTS-1:0] busy;

  logic [ENT_W-1:0]     rd_data;
  logic [FILL_W-1:0]    ent_fill;
  logic [TIME_BITS-1:0] ent_end;
  logic                 ent_busy;
  logic                 take;
  logic                 release_slot;
  logic                 counted;
  logic [FILL_W-1:0]    eff_fill;
  logic [FILL_W-1:0]    waste_add;
  logic [SUM_W:0]       waste_sum;
  logic [SUM_W:0]       used_sum;
  logic                 out_valid_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      part_count <= PART_COUNT_RST;
      part_size  <= PART_SIZE_RST;
      os_base    <= OS_BASE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PART_COUNT: part_count <= cfg_data[COUNT_W-1:0];
        CFG_PART_SIZE:  part_size  <= cfg_data[FILL_W-1:0];
        CFG_OS_BASE:    os_base    <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the partition count to the slots that exist
  assign count_use = (32'(part_count) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
                                                   : CNT_W'(part_count);

  // Slot entry table: fill in the low bits, finish time above
  ffpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (take),
    .wr_addr (proc_idx),
    .wr_data ({fin_q, req_q}),
    .rd_en   (cmd.issue),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign ent_fill = rd_data[FILL_W-1:0];
  assign ent_end  = rd_data[ENT_W-1:FILL_W];
  assign ent_busy = busy[proc_idx];

  // Per-slot decision for the entry read in the previous cycle
  always_comb begin
    take         = proc_vld && (mode_q == MODE_ARRIVAL) && !placed_q && !ent_busy
                   && (req_q <= part_size);
    release_slot = proc_vld && (mode_q == MODE_TICK) && ent_busy && (ent_end == time_q);
    counted      = proc_vld && ((ent_busy && !release_slot) || take);
    eff_fill     = take ? req_q : ent_fill;
    waste_add    = (part_size > eff_fill) ? (part_size - eff_fill) : '0;
    waste_sum    = {1'b0, waste_acc} + (SUM_W + 1)'(waste_add);
    used_sum     = {1'b0, used_acc} + (SUM_W + 1)'(eff_fill);
  end

  // Pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
    end else begin
      proc_vld <= cmd.issue;
    end
  end

  // Item latch, scan pointer, scan accumulators and placement result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q    <= in_mode;
      req_q     <= in_req;
      fin_q     <= TIME_BITS'(in_fin);
      rd_idx    <= '0;
      addr_acc  <= ADDR_W'(os_base);
      placed_q  <= 1'b0;
      slot_q    <= '0;
      addr_q    <= '0;
      waste_acc <= '0;
      used_acc  <= '0;
      freed_q   <= '0;
    end else begin
      if (cmd.issue) begin
        rd_idx   <= rd_idx + CNT_W'(1);
        proc_idx <= rd_idx[IDX_W-1:0];
      end
      if (proc_vld) begin
        addr_acc <= addr_acc + ADDR_W'(part_size);
      end
      if (take) begin
        placed_q <= 1'b1;
        slot_q   <= proc_idx;
        addr_q   <= addr_acc;
      end
      if (release_slot) begin
        freed_q <= freed_q + CNT_W'(1);
      end
      if (counted) begin
        waste_acc <= (waste_sum > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : waste_sum[SUM_W-1:0];
        used_acc  <= (used_sum > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : used_sum[SUM_W-1:0];
      end
    end
  end

  // Occupancy bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (take) begin
      busy[proc_idx] <= 1'b1;
    end else if (release_slot) begin
      busy[proc_idx] <= 1'b0;
    end
  end

  // Time counter and running totals
  assign failures_next = ((mode_q == MODE_ARRIVAL) && !placed_q && (failures_q != TOTAL_MAX))
                         ? failures_q + TOTAL_W'(1) : failures_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_q     <= '0;
      arrivals_q <= '0;
      failures_q <= '0;
    end else begin
      if (cmd.start) begin
        if (in_mode == MODE_TICK) begin
          time_q <= time_q + TIME_BITS'(1);
        end else if (arrivals_q != TOTAL_MAX) begin
          arrivals_q <= arrivals_q + TOTAL_W'(1);
        end
      end
      if (cmd.finish) begin
        failures_q <= failures_next;
      end
    end
  end

  // Result register, held until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= {1'b0, 16'(time_q), 5'(freed_q), arrivals_q, failures_next,
                   used_acc, waste_acc, addr_q, 4'(slot_q), placed_q};
    end
  end

  assign out_valid     = out_valid_q;
  assign sts.more      = rd_idx < count_use;
  assign sts.scan_done = !(rd_idx < count_use) && !proc_vld;
  assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ----- src/first_fit_fixed_partition_allocator_top.sv -----
// First-fit allocator over equal fixed partitions starting at os_base. A tick
// transaction (tuser 0) advances the time counter and frees every partition whose
// finish time matches; an arrival transaction (tuser 1) takes the lowest free
// partition that fits. Each input transaction yields one result transaction with
// placement, occupancy sums and running totals. One item is in work at a time: the
// next is accepted once the slot table has been read, one partition per cycle through
// a single RAM read port, and the result loaded. The result register lets the next
// item be accepted while a result waits. The configuration port is always ready;
// write it only while the block is idle.
module first_fit_fixed_partition_allocator_top
  import ffpa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // request_size[7:0], finish_time[23:8]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // placed[0], slot_index[4:1], start_address[17:5], internal_waste[29:18],
  // used_space[41:30], failure_total[57:42], arrival_total[73:58],
  // freed_now[78:74], time_now[94:79], zero[95]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  ffpa_cmd_t cmd;
  ffpa_sts_t sts;

  assign cfg_ready = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffpa_datapath #(
    .MAX_SLOTS (MAX_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (s_axis_tuser),
    .in_req    (s_axis_tdata[FILL_W-1:0]),
    .in_fin    (s_axis_tdata[FILL_W+FIN_W-1:FILL_W]),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  // One item at a time: after a transaction the input side closes
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // A result is loaded only into a free result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // A new result shows up only after the finish step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.finish))
    else $error("result valid without a finished item");
`endif

endmodule

// ----- tb/first_fit_fixed_partition_allocator_top_tb.sv -----
module first_fit_fixed_partition_allocator_top_tb;
  import ffpa_pkg::*;

  // Result transaction as packed on m_axis_tdata, highest field first
  typedef struct packed {
    logic                 pad;
    logic [15:0]          time_now;
    logic [4:0]           freed_now;
    logic [TOTAL_W-1:0]   arrival_total;
    logic [TOTAL_W-1:0]   failure_total;
    logic [SUM_W-1:0]     used_space;
    logic [SUM_W-1:0]     internal_waste;
    logic [ADDR_W-1:0]    start_address;
    logic [3:0]           slot_index;
    logic                 placed;
  } alloc_result_t;

  // Directed row: item fields plus placement typed in by hand
  typedef struct packed {
    logic               mode;
    logic [FILL_W-1:0]  req;
    logic [FIN_W-1:0]   fin;
    logic               placed;
    logic [3:0]         slot;
    logic [ADDR_W-1:0]  addr;
  } directed_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow of the allocator state
  logic [4:0]           part_count;
  logic [FILL_W-1:0]    part_size;
  logic [BASE_W-1:0]    part_base;
  logic [15:0]          clock_now;
  logic                 busy [16];
  logic [FILL_W-1:0]    fill [16];
  logic [FIN_W-1:0]     end_at [16];
  logic [TOTAL_W-1:0]   fail_cnt;
  logic [TOTAL_W-1:0]   arrive_cnt;

  alloc_result_t expected_results[$];
  int  mismatches;
  int  stall_left;
  int  quiet_cycles;
  bit  idle_on;

  directed_row_t directed_tab [NUM_DIRECTED] = '{
    // after reset: 7 partitions of 8 units from address 8
    '{MODE_TICK,    8'd0,   16'd0,     1'b0, 4'd0, 13'd0},
    '{MODE_ARRIVAL, 8'd8,   16'd5,     1'b1, 4'd0, 13'd8},
    '{MODE_ARRIVAL, 8'd0,   16'd3,     1'b1, 4'd1, 13'd16},
    '{MODE_ARRIVAL, 8'd9,   16'hFFFF,  1'b0, 4'd0, 13'd0},
    '{MODE_ARRIVAL, 8'd255, 16'hFFFF,  1'b0, 4'd0, 13'd0},
    '{MODE_ARRIVAL, 8'd1,   16'd2,     1'b1, 4'd2, 13'd24},
    '{MODE_TICK,    8'd255, 16'hFFFF,  1'b0, 4'd0, 13'd0},
    '{MODE_TICK,    8'd0,   16'd0,     1'b0, 4'd0, 13'd0},
    '{MODE_ARRIVAL, 8'd4,   16'hAAAA,  1'b1, 4'd1, 13'd16},
    '{MODE_ARRIVAL, 8'd7,   16'h5555,  1'b1, 4'd2, 13'd24},
    '{MODE_ARRIVAL, 8'd2,   16'hFFFF,  1'b1, 4'd3, 13'd32},
    '{MODE_ARRIVAL, 8'd8,   16'd0,     1'b1, 4'd4, 13'd40},
    '{MODE_ARRIVAL, 8'd5,   16'd10,    1'b1, 4'd5, 13'd48},
    '{MODE_ARRIVAL, 8'd3,   16'd6,     1'b1, 4'd6, 13'd56},
    // table full
    '{MODE_ARRIVAL, 8'd1,   16'd9,     1'b0, 4'd0, 13'd0},
    '{MODE_TICK,    8'd0,   16'd0,     1'b0, 4'd0, 13'd0},
    '{MODE_TICK,    8'd0,   16'd0,     1'b0, 4'd0, 13'd0},
    '{MODE_ARRIVAL, 8'd0,   16'd7,     1'b1, 4'd0, 13'd8},
    '{MODE_TICK,    8'd0,   16'd0,     1'b0, 4'd0, 13'd0},
    '{MODE_TICK,    8'd0,   16'd0,     1'b0, 4'd0, 13'd0},
    '{MODE_ARRIVAL, 8'd128, 16'd20,    1'b0, 4'd0, 13'd0},
    '{MODE_ARRIVAL, 8'd6,   16'd8,     1'b1, 4'd0, 13'd8}
  };

  first_fit_fixed_partition_allocator_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the shadow state by one item and return the result it causes
  function automatic alloc_result_t advance_allocator(logic mode, logic [FILL_W-1:0] req,
                                                      logic [FIN_W-1:0] fin);
    alloc_result_t r;
    int n;
    int waste;
    int used;
    r = '0;
    waste = 0;
    used = 0;
    n = (part_count > 5'd16) ? 16 : int'(part_count);
    if (mode == MODE_TICK) begin
      clock_now = clock_now + 16'd1;
      for (int i = 0; i < n; i++) begin
        if (busy[i] && end_at[i] == clock_now) begin
          busy[i] = 1'b0;
          fill[i] = '0;
          r.freed_now = r.freed_now + 5'd1;
        end
      end
    end else begin
      if (arrive_cnt != TOTAL_MAX) arrive_cnt = arrive_cnt + TOTAL_W'(1);
      for (int i = 0; i < n; i++) begin
        if (!r.placed && !busy[i] && req <= part_size) begin
          busy[i] = 1'b1;
          fill[i] = req;
          end_at[i] = fin;
          r.placed = 1'b1;
          r.slot_index = 4'(i);
          r.start_address = ADDR_W'(int'(part_base) + i * int'(part_size));
        end
      end
      if (!r.placed && fail_cnt != TOTAL_MAX) fail_cnt = fail_cnt + TOTAL_W'(1);
    end
    // Occupancy sums over the partitions in use
    for (int i = 0; i < n; i++) begin
      if (busy[i]) begin
        if (part_size > fill[i]) waste += int'(part_size) - int'(fill[i]);
        used += int'(fill[i]);
      end
    end
    r.internal_waste = (waste > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(waste);
    r.used_space = (used > int'(SUM_MAX)) ? SUM_MAX : SUM_W'(used);
    r.failure_total = fail_cnt;
    r.arrival_total = arrive_cnt;
    r.time_now = clock_now;
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Offer one item, wait for its transaction, then record the expected result
  task automatic send_item(logic mode, logic [FILL_W-1:0] req, logic [FIN_W-1:0] fin,
                           bit typed, directed_row_t row);
    alloc_result_t want;
    bit taken;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {fin, req};
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    want = advance_allocator(mode, req, fin);
    if (typed) begin
      want.placed = row.placed;
      want.slot_index = row.slot;
      want.start_address = row.addr;
    end
    expected_results.insert(expected_results.size(), want);
  endtask

  // Leave cfg_valid high on return; the caller lowers it after the last write
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    case (idx)
      CFG_PART_COUNT: part_count = data[4:0];
      CFG_PART_SIZE:  part_size = data[7:0];
      CFG_OS_BASE:    part_base = data;
      default: ;
    endcase
  endtask

  // Hold the input until every pending result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (MAX_SLOTS_DEF + 8) @(posedge clk);
  endtask

  // Receiver: stall in random bursts while idling is enabled
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest expectation
  always @(negedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    string bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result %h", got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          bad = "";
          if (got.placed !== want.placed) bad = {bad, " placed"};
          if (got.slot_index !== want.slot_index) bad = {bad, " slot_index"};
          if (got.start_address !== want.start_address) bad = {bad, " start_address"};
          if (got.internal_waste !== want.internal_waste) bad = {bad, " internal_waste"};
          if (got.used_space !== want.used_space) bad = {bad, " used_space"};
          if (got.failure_total !== want.failure_total) bad = {bad, " failure_total"};
          if (got.arrival_total !== want.arrival_total) bad = {bad, " arrival_total"};
          if (got.freed_now !== want.freed_now) bad = {bad, " freed_now"};
          if (got.time_now !== want.time_now) bad = {bad, " time_now"};
          if (got.pad !== want.pad) bad = {bad, " pad"};
          flag_error($sformatf("mismatch in%s: expected %h got %h", bad, want, got));
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(negedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [4:0]        c;
    logic [FILL_W-1:0] s;
    logic [BASE_W-1:0] b;
    logic              mode;
    logic [FILL_W-1:0] req;
    logic [FIN_W-1:0]  fin;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_PART_COUNT;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_TICK;
    mismatches = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    part_count = PART_COUNT_RST;
    part_size = PART_SIZE_RST;
    part_base = OS_BASE_RST;
    clock_now = '0;
    fail_cnt = '0;
    arrive_cnt = '0;
    for (int i = 0; i < 16; i++) begin
      busy[i] = 1'b0;
      fill[i] = '0;
      end_at[i] = '0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows on the reset geometry
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(directed_tab[i].mode, directed_tab[i].req, directed_tab[i].fin, 1'b1,
                directed_tab[i]);

    // Phases: extremes first, then random geometry; no idling in phase 3 or the last one
    for (int p = 0; p < 12; p++) begin
      settle();
      case (p)
        0: begin c = 5'd16; s = 8'd255; b = 12'd4095; end
        1: begin c = 5'd3;  s = 8'd1;   b = 12'd0;    end
        2: begin c = 5'd31; s = 8'd17;  b = 12'd100;  end
        3: begin c = 5'd0;  s = 8'($urandom); b = 12'($urandom); end
        default: begin
          c = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(1, 16));
          s = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
          b = 12'($urandom_range(0, 4095));
        end
      endcase
      write_cfg(CFG_PART_COUNT, {7'($urandom), c});
      write_cfg(CFG_PART_SIZE, {4'($urandom), s});
      write_cfg(CFG_OS_BASE, b);
      cfg_valid <= 1'b0;
      idle_on = (p != 3) && (p != 11);

      // Random items; with no partitions every arrival fails
      for (int i = 0; i < 148; i++) begin
        mode = ($urandom_range(0, 99) < 55) ? MODE_ARRIVAL : MODE_TICK;
        req = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                          : 8'($urandom_range(0, int'(part_size)));
        fin = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                          : clock_now + 16'($urandom_range(1, 40));
        send_item(mode, req, fin, 1'b0, '0);
        if (i == 80 || $urandom_range(0, 99) == 0) drain();
      end
    end

    // Let the last results come back, then allow for the block's latency
    drain();
    repeat (MAX_SLOTS_DEF + 16) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
